// ----- rtl/length_prefixed_frame_parser_assert.svh -----
// Assertion macros used by the frame parser checker
`ifndef LENGTH_PREFIXED_FRAME_PARSER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define LPFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame parser check failed");

// Next-cycle implication, disabled while reset is asserted
`define LPFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame parser check failed");

`endif

// ----- rtl/lpfp_pkg.sv -----
// Package with shared constants and result kinds of the frame parser
`timescale 1ns / 1ps

package lpfp_pkg;

	// Width of the header length and the payload countdown
	localparam int LEN_BITS = 16;

	// Results one input byte can yield at most
	localparam int MAX_RES = 4;

	// Result queue geometry
	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_AW    = 3;

	// Characters recognised by the parser
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_LA      = 8'h61;
	localparam logic [7:0] CH_LF_HEX  = 8'h66;
	localparam logic [7:0] CH_UA      = 8'h41;
	localparam logic [7:0] CH_UF      = 8'h46;

	// Result kinds, carried on the output user field
	typedef enum logic [2:0] {
		KIND_TYPE    = 3'd0,
		KIND_KEY     = 3'd1,
		KIND_VALUE   = 3'd2,
		KIND_KEPT    = 3'd3,
		KIND_DROPPED = 3'd4,
		KIND_FEND    = 3'd5,
		KIND_HERR    = 3'd6
	} kind_t;

endpackage

// ----- rtl/length_prefixed_frame_parser.sv -----
// Length-prefixed frame parser with percent-decoding of field values
// The results of an accepted byte are registered into the result queue and offered from its head.
// Throughput: one byte per cycle while the 8-entry result queue holds four or fewer
// results; a byte yielding k results occupies k queue entries, so input
// stalls only when bursts of several results build up in the queue.
// Reset: arst_n clears the parser state to the header phase and empties the queue.
`timescale 1ns / 1ps

module length_prefixed_frame_parser (
	input  logic       clk,
	input  logic       arst_n,
	// s_tdata: [7:0] in_byte
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	// m_tdata: [7:0] out_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	// m_tuser: [2:0] out_kind
	output logic [2:0] m_tuser,
	output logic       m_tlast
);
	import lpfp_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TYPE,
		PH_KEY,
		PH_VALUE,
		PH_SKIP
	} phase_t;

	// Results gathered for one input byte
	typedef struct packed {
		logic [2:0]                n;
		logic                      ovf;
		logic [MAX_RES-1:0][7:0]   b;
		kind_t [MAX_RES-1:0]       k;
	} res_list_t;

	localparam int CNT_W = QUEUE_AW + 1;

	// Append one result; past the limit only flag the overflow
	function automatic res_list_t add_res(res_list_t l, kind_t k, logic [7:0] b);
		res_list_t r;
		r = l;
		if (l.n == 3'(MAX_RES)) begin
			r.ovf = 1'b1;
		end else begin
			r.k[l.n[1:0]] = k;
			r.b[l.n[1:0]] = b;
			r.n = l.n + 3'd1;
		end
		return r;
	endfunction

	// Emit a pending escape literally
	function automatic res_list_t flush_res(res_list_t l, logic [1:0] esc, logic [7:0] held);
		res_list_t r;
		r = l;
		if (esc == 2'd1) begin
			r = add_res(r, KIND_VALUE, CH_PERCENT);
		end else if (esc == 2'd2) begin
			r = add_res(r, KIND_VALUE, CH_PERCENT);
			r = add_res(r, KIND_VALUE, held);
		end
		return r;
	endfunction

	function automatic logic is_dec(logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_hex(logic [7:0] c);
		return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF_HEX)) ||
			((c >= CH_UA) && (c <= CH_UF));
	endfunction

	// Letters a-f and A-F have low nibbles 1..6, so adding nine gives 10..15
	function automatic logic [3:0] hex_val(logic [7:0] c);
		return is_dec(c) ? c[3:0] : c[3:0] + 4'd9;
	endfunction

	// Parser state
	phase_t              phase_q, phase_d;
	logic [LEN_BITS-1:0] len_q, len_d;
	logic                digit_q, digit_d;
	logic [LEN_BITS-1:0] rem_q, rem_d;
	logic                keyne_q, keyne_d;
	logic                lopen_q, lopen_d;
	logic [1:0]          esc_q, esc_d;
	logic [7:0]          held_q, held_d;
	logic                owed_q, owed_d;

	// Result queue
	logic [7:0]          q_byte [QUEUE_DEPTH];
	kind_t               q_kind [QUEUE_DEPTH];
	logic                q_last [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                in_acc, out_acc;
	res_list_t           rl;
	logic [LEN_BITS+3:0] prod;

	assign s_tready = (cnt_q <= CNT_W'(QUEUE_DEPTH - MAX_RES));
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = (cnt_q != '0);
	assign out_acc  = m_tvalid && m_tready;
	assign m_tdata  = q_byte[rd_ptr_q];
	assign m_tuser  = q_kind[rd_ptr_q];
	assign m_tlast  = q_last[rd_ptr_q];

	// Header length times ten plus the new digit
	assign prod = ({4'b0, len_q} << 3) + ({4'b0, len_q} << 1) +
		(LEN_BITS + 4)'(s_tdata[3:0]);

	// Work out the results and next state for the byte on the input
	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		digit_d = digit_q;
		rem_d   = rem_q;
		keyne_d = keyne_q;
		lopen_d = lopen_q;
		esc_d   = esc_q;
		held_d  = held_q;
		owed_d  = owed_q;
		rl      = '0;

		// Deliver a frame end left over from the previous byte first
		if (owed_q) begin
			owed_d = 1'b0;
			rl = add_res(rl, KIND_FEND, 8'd0);
		end

		if (phase_q == PH_HEADER) begin
			if (is_dec(s_tdata)) begin
				if (prod[LEN_BITS+3:LEN_BITS] != 4'd0) begin
					rl = add_res(rl, KIND_HERR, 8'd0);
					len_d   = '0;
					digit_d = 1'b0;
				end else begin
					len_d   = prod[LEN_BITS-1:0];
					digit_d = 1'b1;
				end
			end else if (s_tdata == CH_LF && digit_q) begin
				rem_d   = len_q;
				len_d   = '0;
				digit_d = 1'b0;
				keyne_d = 1'b0;
				lopen_d = 1'b0;
				esc_d   = 2'd0;
				held_d  = 8'd0;
				if (len_q == '0) begin
					rl = add_res(rl, KIND_FEND, 8'd0);
				end else begin
					phase_d = PH_TYPE;
				end
			end else begin
				rl = add_res(rl, KIND_HERR, 8'd0);
				len_d   = '0;
				digit_d = 1'b0;
			end
		end else begin
			rem_d = rem_q - LEN_BITS'(1);
			case (phase_q)
				PH_TYPE: begin
					if (s_tdata == CH_LF) begin
						phase_d = PH_KEY;
						keyne_d = 1'b0;
						lopen_d = 1'b0;
						esc_d   = 2'd0;
						held_d  = 8'd0;
					end else begin
						rl = add_res(rl, KIND_TYPE, s_tdata);
					end
				end
				PH_KEY: begin
					if (s_tdata == CH_LF) begin
						rl = add_res(rl, KIND_DROPPED, 8'd0);
						keyne_d = 1'b0;
						lopen_d = 1'b0;
						esc_d   = 2'd0;
						held_d  = 8'd0;
					end else if (s_tdata == CH_EQUAL) begin
						phase_d = keyne_q ? PH_VALUE : PH_SKIP;
						lopen_d = 1'b1;
					end else begin
						rl = add_res(rl, KIND_KEY, s_tdata);
						keyne_d = 1'b1;
						lopen_d = 1'b1;
					end
				end
				PH_VALUE: begin
					if (s_tdata == CH_LF) begin
						rl = flush_res(rl, esc_q, held_q);
						rl = add_res(rl, KIND_KEPT, 8'd0);
						phase_d = PH_KEY;
						keyne_d = 1'b0;
						lopen_d = 1'b0;
						esc_d   = 2'd0;
						held_d  = 8'd0;
					end else if (esc_q == 2'd1 && is_hex(s_tdata)) begin
						// First hex digit of an escape: hold it
						held_d = s_tdata;
						esc_d  = 2'd2;
					end else if (esc_q == 2'd2 && is_hex(s_tdata)) begin
						// Second hex digit: emit the decoded byte
						rl = add_res(rl, KIND_VALUE, {hex_val(held_q), hex_val(s_tdata)});
						esc_d = 2'd0;
					end else begin
						// Bad or no escape: flush it, then treat the byte as plain
						rl = flush_res(rl, esc_q, held_q);
						if (s_tdata == CH_PERCENT) begin
							esc_d = 2'd1;
						end else begin
							esc_d = 2'd0;
							rl = add_res(rl, KIND_VALUE, s_tdata);
						end
					end
				end
				default: begin
					if (s_tdata == CH_LF) begin
						rl = add_res(rl, KIND_DROPPED, 8'd0);
						phase_d = PH_KEY;
						keyne_d = 1'b0;
						lopen_d = 1'b0;
						esc_d   = 2'd0;
						held_d  = 8'd0;
					end else begin
						lopen_d = 1'b1;
					end
				end
			endcase

			// Close the open line and the frame on its last payload byte
			if (rem_d == '0) begin
				if (phase_d == PH_VALUE) begin
					rl = flush_res(rl, esc_d, held_d);
					rl = add_res(rl, KIND_KEPT, 8'd0);
				end else if ((phase_d == PH_KEY || phase_d == PH_SKIP) && lopen_d) begin
					rl = add_res(rl, KIND_DROPPED, 8'd0);
				end
				rl = add_res(rl, KIND_FEND, 8'd0);
				phase_d = PH_HEADER;
				len_d   = '0;
				digit_d = 1'b0;
				keyne_d = 1'b0;
				lopen_d = 1'b0;
				esc_d   = 2'd0;
				held_d  = 8'd0;
			end
		end

		// A dropped result owes a frame end to the next byte
		if (rl.ovf) begin
			owed_d = 1'b1;
		end
	end

	// State and write pointer advance on accepted requests, read pointer on taken results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			len_q    <= '0;
			digit_q  <= 1'b0;
			rem_q    <= '0;
			keyne_q  <= 1'b0;
			lopen_q  <= 1'b0;
			esc_q    <= 2'd0;
			held_q   <= 8'd0;
			owed_q   <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (in_acc) begin
				phase_q  <= phase_d;
				len_q    <= len_d;
				digit_q  <= digit_d;
				rem_q    <= rem_d;
				keyne_q  <= keyne_d;
				lopen_q  <= lopen_d;
				esc_q    <= esc_d;
				held_q   <= held_d;
				owed_q   <= owed_d;
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(rl.n);
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			cnt_q <= cnt_q + (in_acc ? CNT_W'(rl.n) : CNT_W'(0)) -
				(out_acc ? CNT_W'(1) : CNT_W'(0));
		end
	end

	// Write the results of an accepted byte into the queue
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (3'(i) < rl.n) begin
					q_byte[wr_ptr_q + QUEUE_AW'(i)] <= rl.b[i];
					q_kind[wr_ptr_q + QUEUE_AW'(i)] <= rl.k[i];
					q_last[wr_ptr_q + QUEUE_AW'(i)] <= (3'(i) == rl.n - 3'd1);
				end
			end
		end
	end

endmodule

// ----- rtl/lpfp_checker.sv -----
// Port-level checker for the frame parser and its bind
`timescale 1ns / 1ps

`include "length_prefixed_frame_parser_assert.svh"

module lpfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [2:0] m_tuser,
	input logic       m_tlast
);
	import lpfp_pkg::*;

	// Whole result word as offered on the output
	logic [11:0] res_word;

	assign res_word = {m_tdata, m_tuser, m_tlast};

	// Only the seven defined result kinds leave the block
	`LPFP_ASSERT_IMP(a_kind_range, clk, arst_n, m_tvalid, m_tuser <= KIND_HERR)

	// Marker results carry a zero byte
	`LPFP_ASSERT_IMP(a_marker_zero, clk, arst_n, m_tvalid && m_tuser >= KIND_KEPT, m_tdata == 8'd0)

	// A header error is always the final result of its byte
	`LPFP_ASSERT_IMP(a_herr_last, clk, arst_n, m_tvalid && m_tuser == KIND_HERR, m_tlast)

	// A stalled result holds
	`LPFP_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(res_word))

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ----- test/tb_top.sv -----
// Self-checking testbench of the frame parser: byte requests in, tagged results checked
`timescale 1ns / 1ps

module tb_top;
	import lpfp_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 9;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_PRINTS   = 100;
	localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS) - 1;

	// Parser phases of the local prediction
	typedef enum logic [2:0] {
		PARSE_HEADER,
		PARSE_TYPE,
		PARSE_KEY,
		PARSE_VALUE,
		PARSE_SKIP
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} parsed_t;

	typedef logic [7:0] byte_q_t[$];

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	int cycle_count    = 0;
	int error_count    = 0;
	int bytes_sent     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int stall_now      = 0;
	int hold_asked     = 0;
	int hold_taken     = 0;
	int hold_left      = 0;

	// Predicted parser state
	parse_phase_t    pp_phase      = PARSE_HEADER;
	longint unsigned pp_len_accum  = 0;
	bit              pp_digit_seen = 1'b0;
	longint unsigned pp_remaining  = 0;
	bit              pp_key_nonempty = 1'b0;
	bit              pp_line_open  = 1'b0;
	int              pp_escape     = 0;
	logic [7:0]      pp_held       = 8'h00;
	bit              pp_fend_owed  = 1'b0;

	parsed_t step_results[$];
	parsed_t expected_q[$];

	length_prefixed_frame_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
	endtask

	// ---------------------------------------------------------------- prediction

	function automatic void put_result(kind_t k, logic [7:0] b);
		parsed_t r;
		// a fifth result is carried over as a frame end on the next byte
		if (step_results.size() >= MAX_RES) begin
			pp_fend_owed = 1'b1;
			return;
		end
		r.data = b;
		r.kind = k;
		r.last = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic int hex_value(logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
		if (c >= CH_LA && c <= CH_LF_HEX) return 10 + int'(c - CH_LA);
		if (c >= CH_UA && c <= CH_UF) return 10 + int'(c - CH_UA);
		return -1;
	endfunction

	function automatic void restart_header();
		pp_len_accum  = 0;
		pp_digit_seen = 1'b0;
	endfunction

	function automatic void restart_line();
		pp_key_nonempty = 1'b0;
		pp_line_open    = 1'b0;
		pp_escape       = 0;
		pp_held         = 8'h00;
	endfunction

	function automatic void plain_value(logic [7:0] b);
		if (b == CH_PERCENT) pp_escape = 1;
		else put_result(KIND_VALUE, b);
	endfunction

	// Emit a pending escape literally
	function automatic void flush_escape();
		if (pp_escape == 1) begin
			put_result(KIND_VALUE, CH_PERCENT);
		end else if (pp_escape == 2) begin
			put_result(KIND_VALUE, CH_PERCENT);
			put_result(KIND_VALUE, pp_held);
		end
		pp_escape = 0;
	endfunction

	function automatic void value_char(logic [7:0] b);
		if (pp_escape == 1) begin
			if (hex_value(b) >= 0) begin
				pp_held   = b;
				pp_escape = 2;
			end else begin
				flush_escape();
				plain_value(b);
			end
		end else if (pp_escape == 2) begin
			if (hex_value(b) >= 0) begin
				put_result(KIND_VALUE, 8'((hex_value(pp_held) << 4) | hex_value(b)));
				pp_escape = 0;
			end else begin
				flush_escape();
				plain_value(b);
			end
		end else begin
			plain_value(b);
		end
	endfunction

	function automatic void header_char(logic [7:0] b);
		longint unsigned next_len;
		if (b >= CH_0 && b <= CH_9) begin
			next_len = pp_len_accum * 10 + longint'(b - CH_0);
			if (next_len > LEN_MAX) begin
				put_result(KIND_HERR, 8'h00);
				restart_header();
			end else begin
				pp_len_accum  = next_len;
				pp_digit_seen = 1'b1;
			end
		end else if (b == CH_LF && pp_digit_seen) begin
			pp_remaining = pp_len_accum;
			restart_header();
			restart_line();
			if (pp_remaining == 0) put_result(KIND_FEND, 8'h00);
			else pp_phase = PARSE_TYPE;
		end else begin
			put_result(KIND_HERR, 8'h00);
			restart_header();
		end
	endfunction

	function automatic void payload_char(logic [7:0] b);
		pp_remaining = (pp_remaining - 1) & LEN_MAX;
		case (pp_phase)
			PARSE_TYPE: begin
				if (b == CH_LF) begin
					pp_phase = PARSE_KEY;
					restart_line();
				end else begin
					put_result(KIND_TYPE, b);
				end
			end
			PARSE_KEY: begin
				if (b == CH_LF) begin
					put_result(KIND_DROPPED, 8'h00);
					restart_line();
				end else if (b == CH_EQUAL) begin
					pp_phase     = pp_key_nonempty ? PARSE_VALUE : PARSE_SKIP;
					pp_line_open = 1'b1;
				end else begin
					put_result(KIND_KEY, b);
					pp_key_nonempty = 1'b1;
					pp_line_open    = 1'b1;
				end
			end
			PARSE_VALUE: begin
				if (b == CH_LF) begin
					flush_escape();
					put_result(KIND_KEPT, 8'h00);
					pp_phase = PARSE_KEY;
					restart_line();
				end else begin
					value_char(b);
				end
			end
			default: begin
				if (b == CH_LF) begin
					put_result(KIND_DROPPED, 8'h00);
					pp_phase = PARSE_KEY;
					restart_line();
				end else begin
					pp_line_open = 1'b1;
				end
			end
		endcase
		// close the frame on its last payload byte
		if (pp_remaining == 0) begin
			if (pp_phase == PARSE_VALUE) begin
				flush_escape();
				put_result(KIND_KEPT, 8'h00);
			end else if ((pp_phase == PARSE_KEY || pp_phase == PARSE_SKIP) && pp_line_open) begin
				put_result(KIND_DROPPED, 8'h00);
			end
			put_result(KIND_FEND, 8'h00);
			pp_phase = PARSE_HEADER;
			restart_header();
			restart_line();
		end
	endfunction

	// Work out the results of one accepted byte and queue them
	function automatic void predict_byte(logic [7:0] b);
		step_results.delete();
		if (pp_fend_owed) begin
			pp_fend_owed = 1'b0;
			put_result(KIND_FEND, 8'h00);
		end
		if (pp_phase == PARSE_HEADER) header_char(b);
		else payload_char(b);
		if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
		foreach (step_results[i]) expected_q.push_back(step_results[i]);
	endfunction

	// ---------------------------------------------------------------- checking

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		parsed_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				report_error($sformatf("unexpected result data %02h kind %0d last %0b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				want = expected_q.pop_front();
				if (m_tdata !== want.data)
					report_error($sformatf("data %02h, expected %02h", m_tdata, want.data));
				if (m_tuser !== want.kind)
					report_error($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
				if (m_tlast !== want.last)
					report_error($sformatf("last %0b, expected %0b", m_tlast, want.last));
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// Pick up hold requests and count the hold down
	always @(posedge clk) begin
		stall_now = recv_stall_pct;
		if (hold_taken != hold_asked) begin
			hold_taken = hold_asked;
			hold_left  = HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left--;
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(0, 99) >= stall_now);
	end

	// ---------------------------------------------------------------- stimulus

	// Offer one byte request, with random gaps ahead of it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_bytes(input byte_q_t q);
		foreach (q[i]) send_byte(q[i]);
	endtask

	function automatic byte_q_t to_bytes(input string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	// Send any leading zeros and a decimal header for hdr_len, then the payload
	task automatic send_frame(input byte_q_t pl, input int zeros, input int hdr_len);
		byte_q_t hdr;
		hdr = to_bytes($sformatf("%0d", hdr_len));
		repeat (zeros) send_byte(CH_0);
		send_bytes(hdr);
		send_byte(CH_LF);
		send_bytes(pl);
	endtask

	// Drop the request line and wait for every expected result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] line_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CH_LF) b = 8'h8A;
		return b;
	endfunction

	function automatic logic [7:0] key_byte();
		logic [7:0] b;
		b = line_byte();
		if (b == CH_EQUAL) b = 8'hBD;
		return b;
	endfunction

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) return 8'(CH_0 + v);
		if ($urandom_range(0, 1) == 0) return 8'(CH_LA + v - 10);
		return 8'(CH_UA + v - 10);
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] b;
		b = line_byte();
		while (hex_value(b) >= 0) b = line_byte();
		return b;
	endfunction

	// Value text: plain bytes, good escapes, bad and cut-off escapes
	function automatic void add_value(ref byte_q_t pl);
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 5))
				0, 1: pl.push_back(line_byte());
				2: begin
					pl.push_back(CH_PERCENT);
					pl.push_back(hex_char());
					pl.push_back(hex_char());
				end
				3: begin
					pl.push_back(CH_PERCENT);
					pl.push_back(non_hex_char());
				end
				4: begin
					pl.push_back(CH_PERCENT);
					pl.push_back(hex_char());
					pl.push_back(non_hex_char());
				end
				default: begin
					pl.push_back(CH_PERCENT);
					if ($urandom_range(0, 1) == 0) pl.push_back(hex_char());
				end
			endcase
		end
	endfunction

	// Type line, then a few key=value lines and the odd malformed one
	function automatic byte_q_t random_payload();
		byte_q_t pl;
		repeat ($urandom_range(0, 3)) pl.push_back(line_byte());
		repeat ($urandom_range(0, 3)) begin
			pl.push_back(CH_LF);
			case ($urandom_range(0, 9))
				0: ;
				1: repeat ($urandom_range(1, 3)) pl.push_back(key_byte());
				2: begin
					pl.push_back(CH_EQUAL);
					repeat ($urandom_range(0, 3)) pl.push_back(line_byte());
				end
				default: begin
					repeat ($urandom_range(1, 3)) pl.push_back(key_byte());
					pl.push_back(CH_EQUAL);
					add_value(pl);
				end
			endcase
		end
		if ($urandom_range(0, 2) != 0) pl.push_back(CH_LF);
		return pl;
	endfunction

	// Mostly well-formed frames; sometimes noise, an oversized or a short header
	task automatic send_random_frame();
		byte_q_t pl;
		logic [7:0] b;
		int zeros;
		pl    = random_payload();
		zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
		case ($urandom_range(0, 9))
			0: begin
				repeat ($urandom_range(1, 3)) begin
					b = 8'($urandom_range(0, 255));
					if (b >= CH_0 && b <= CH_9) b = 8'h78;
					send_byte(b);
				end
				send_frame(pl, zeros, pl.size());
			end
			1: begin
				send_bytes(to_bytes("99999"));
				send_frame(pl, zeros, pl.size());
			end
			2: begin
				if (pl.size() >= 2) begin
					send_frame(pl, zeros, pl.size() - 1);
					send_byte(8'h78);
				end else begin
					send_frame(pl, zeros, pl.size());
				end
			end
			default: send_frame(pl, zeros, pl.size());
		endcase
	endtask

	// ---------------------------------------------------------------- tests

	// Zero length, empty header, bad byte, length just over the maximum
	task automatic test_header_errors();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_bytes(to_bytes("0\n"));
		send_bytes(to_bytes("\nx"));
		send_bytes(to_bytes("65536"));
		drain_results();
	endtask

	// Carried frame end, dropped lines, escapes good, bad and cut off, leading zeros
	task automatic test_frame_rules();
		send_frame(to_bytes("T\nk=%4Z"), 0, 7);
		send_bytes(to_bytes("0\n"));
		send_frame(to_bytes("\n=a\nq\nx=%G%4g\nk=%41%"), 1, 20);
		drain_results();
	endtask

	task automatic test_random_stream(input int send_pct, input int recv_pct, input int count);
		int stop_at;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		stop_at        = bytes_sent + count;
		while (bytes_sent < stop_at) send_random_frame();
		drain_results();
	endtask

	// Hold the receiver off while bytes keep coming, so the input stalls
	task automatic test_backpressure();
		int stop_at;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_asked++;
		stop_at = bytes_sent + 20;
		while (bytes_sent < stop_at) send_random_frame();
		drain_results();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		test_header_errors();
		test_frame_rules();
		test_random_stream(0, 0, 20);
		test_random_stream(65, 0, 20);
		test_random_stream(0, 65, 20);
		test_random_stream(13, 13, 20);
		test_backpressure();
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
